// ===== hw/rtl/pstk_pkg.sv =====
// Shared types and constants for the pair stack with search.
`timescale 1ns / 1ps

package pstk_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int VAL_W       = 32;

  // Command codes
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_FIND  = 2'd2,
    OP_PRINT = 2'd3
  } op_t;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_FOUND     = 2'd0,
    KIND_NOT_FOUND = 2'd1,
    KIND_ENTRY     = 2'd2,
    KIND_FULL      = 2'd3
  } kind_t;

  // One stored entry
  typedef struct packed {
    logic signed [VAL_W-1:0] first;
    logic signed [VAL_W-1:0] second;
  } pair_t;

  // Storage port request from the controller
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    pair_t            wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ===== hw/rtl/pstk_store.sv =====
// Entry storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module pstk_store import pstk_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output pair_t    rd_data
);

  pair_t mem [STACK_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== hw/rtl/pstk_ctrl.sv =====
// Command sequencer: stack pointer, entry walk, pair compare and result registers.
`timescale 1ns / 1ps

module pstk_ctrl import pstk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              opcode,
  input  logic signed [VAL_W-1:0] first_value,
  input  logic signed [VAL_W-1:0] second_value,
  output mem_req_t                req,
  input  pair_t                   rd_data,
  output logic                    strobe,
  output logic [1:0]              kind,
  output logic signed [VAL_W-1:0] entry_first,
  output logic signed [VAL_W-1:0] entry_second,
  output logic                    last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] ptr;
  logic             is_find;
  pair_t            key;
  logic             hit;
  logic             data_vld;
  logic             data_last;

  logic accept;
  logic full;
  logic ptr_last;
  logic eq;
  logic hit_next;
  logic strobe_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);
  assign full   = (count == CNT_W'(STACK_DEPTH));

  // Last stored entry reached by the walk
  assign ptr_last = ((CNT_W'(ptr) + CNT_W'(1)) == count);

  // Shared pair compare on the entry just read
  assign eq       = (rd_data == key);
  assign hit_next = hit || eq;

  // A result goes out for a refused push, a find on an empty stack,
  // every printed entry and the end of a find walk
  assign strobe_next = (accept && (opcode == OP_PUSH) && full)
                    || (accept && (opcode == OP_FIND) && (count == '0))
                    || (((state == ST_SCAN) || (state == ST_DRAIN)) && data_vld
                        && (!is_find || data_last));

  // Storage requests: push writes on top, the walk reads one entry a cycle
  always_comb begin
    req.wr_en          = accept && (opcode == OP_PUSH) && !full;
    req.wr_addr        = count[IDX_W-1:0];
    req.wr_data.first  = first_value;
    req.wr_data.second = second_value;
    req.rd_en          = (state == ST_SCAN);
    req.rd_addr        = ptr;
  end

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ptr       <= '0;
      hit       <= 1'b0;
      data_vld  <= 1'b0;
      data_last <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      strobe <= strobe_next;
      case (state)
        ST_IDLE: begin
          data_vld <= 1'b0;
          if (accept) begin
            case (opcode)
              OP_PUSH: begin
                if (full) begin
                  kind         <= KIND_FULL;
                  entry_first  <= '0;
                  entry_second <= '0;
                  last         <= 1'b1;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              OP_POP: begin
                if (count != '0) begin
                  count <= count - CNT_W'(1);
                end
              end
              OP_FIND: begin
                key.first  <= first_value;
                key.second <= second_value;
                is_find    <= 1'b1;
                hit        <= 1'b0;
                ptr        <= '0;
                if (count == '0) begin
                  kind         <= KIND_NOT_FOUND;
                  entry_first  <= '0;
                  entry_second <= '0;
                  last         <= 1'b1;
                end else begin
                  state <= ST_SCAN;
                end
              end
              default: begin
                is_find <= 1'b0;
                ptr     <= '0;
                if (count != '0) begin
                  state <= ST_SCAN;
                end
              end
            endcase
          end
        end

        ST_SCAN, ST_DRAIN: begin
          // Handle the entry read in the previous cycle
          if (data_vld) begin
            if (is_find) begin
              hit <= hit_next;
              if (data_last) begin
                kind         <= hit_next ? KIND_FOUND : KIND_NOT_FOUND;
                entry_first  <= '0;
                entry_second <= '0;
                last         <= 1'b1;
              end
            end else begin
              kind         <= KIND_ENTRY;
              entry_first  <= rd_data.first;
              entry_second <= rd_data.second;
              last         <= data_last;
            end
          end
          // Issue the next read, or finish
          if (state == ST_SCAN) begin
            data_vld  <= 1'b1;
            data_last <= ptr_last;
            ptr       <= ptr + IDX_W'(1);
            if (ptr_last) begin
              state <= ST_DRAIN;
            end
          end else begin
            data_vld <= 1'b0;
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/pair_stack_with_search_core.sv =====
// Top level of the pair stack with search.
`timescale 1ns / 1ps

// A bounded stack of signed 32-bit pairs, STACK_DEPTH entries deep, driven by
// one command per transaction (start high while busy is low). Push and pop
// leave busy low; a push on a full stack answers with a full result on the
// next cycle. Find and print walk the stored entries from bottom to top
// through one read port, one entry per cycle, keeping busy high while they
// run (busy stays low on an empty stack). Find answers found or not
// found once the whole walk is done; print streams one result per cycle, the
// final one marked by last. Every result is shown for exactly one cycle with
// strobe high and must be taken then: there is no way to stall the outputs.
module pair_stack_with_search_core import pstk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              opcode,
  input  logic signed [VAL_W-1:0] first_value,
  input  logic signed [VAL_W-1:0] second_value,
  output logic                    strobe,
  output logic [1:0]              kind,
  output logic signed [VAL_W-1:0] entry_first,
  output logic signed [VAL_W-1:0] entry_second,
  output logic                    last
);

  mem_req_t req;
  pair_t    rd_data;

  // Entry storage
  pstk_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // Command sequencer
  pstk_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .first_value  (first_value),
    .second_value (second_value),
    .req          (req),
    .rd_data      (rd_data),
    .strobe       (strobe),
    .kind         (kind),
    .entry_first  (entry_first),
    .entry_second (entry_second),
    .last         (last)
  );

endmodule

// ===== hw/rtl/pstk_checker.sv =====
// Port-level checks for the pair stack with search, bound to the top level.
`timescale 1ns / 1ps

module pstk_checker import pstk_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic [1:0]              opcode,
  input logic                    strobe,
  input logic [1:0]              kind,
  input logic signed [VAL_W-1:0] entry_first,
  input logic signed [VAL_W-1:0] entry_second,
  input logic                    last
);

  // A printed stream has no gaps until its final entry
  a_stream_gapless: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("print stream broke before its last entry");

  // Find and full answers are single results
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind != KIND_ENTRY) |-> last)
    else $error("non-entry result without last");

  // Non-entry results carry zero values
  a_zero_values: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind != KIND_ENTRY) |-> (entry_first == '0) && (entry_second == '0))
    else $error("non-entry result with nonzero values");

  // The block stays busy while a print stream is still running
  a_busy_stream: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("not busy in the middle of a print stream");

  // A pop never answers
  a_pop_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (opcode == OP_POP) |=> !strobe)
    else $error("result after a pop");

endmodule

bind pair_stack_with_search_core pstk_checker u_pstk_checker (.*);
